@@ src/leb_pkg.sv @@
// ----------------------------------------------------------------------------
// LEB128 decoder package
// Kind codes, error codes and the structs passed between the decoder modules.
// ----------------------------------------------------------------------------
package leb_pkg;

   localparam logic [1:0] KIND_U32 = 2'd0;
   localparam logic [1:0] KIND_S32 = 2'd1;
   localparam logic [1:0] KIND_S64 = 2'd2;
   localparam logic [1:0] KIND_RSV = 2'd3;

   localparam logic [1:0] ERR_OK               = 2'd0;
   localparam logic [1:0] ERR_LEN_OUT_OF_BOUND = 2'd1;
   localparam logic [1:0] ERR_REP_TOO_LONG     = 2'd2;
   localparam logic [1:0] ERR_TOO_LARGE        = 2'd3;

   localparam logic [3:0] LAST_POS_32 = 4'd4;
   localparam logic [3:0] LAST_POS_64 = 4'd9;

   typedef struct packed {
      logic [63:0] acc;
      logic [3:0]  pos;
      logic [1:0]  kind;
   } state_type;

   typedef struct packed {
      logic               valid;
      logic signed [63:0] value;
      logic [1:0]         error_code;
   } result_type;

endpackage

@@ src/leb_if.sv @@
// ----------------------------------------------------------------------------
// LEB128 decoder channels
// Valid/ready channels for the byte requests and the decoded results.
// ----------------------------------------------------------------------------
interface leb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, kind, data_byte, buffer_end, input ready);
   modport sink   (input valid, kind, data_byte, buffer_end, output ready);
endinterface

interface leb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic [1:0]         error_code;

   modport source (output valid, value, error_code, input ready);
   modport sink   (input valid, value, error_code, output ready);
endinterface

@@ src/leb128_integer_decoder.sv @@
// A result is registered in the output entry, or in the skid entry while the output stalls.
// Throughput: one byte request per cycle while the skid entry is empty; the
// single decode step between state and result registers sets that figure.
// A two-entry result buffer keeps requests flowing while a result is stalled.
// Reset is synchronous and active high; it clears the decode state and the
// result buffer, after which the block is ready at once.
// ----------------------------------------------------------------------------
// LEB128 integer decoder
// Decodes unsigned 32, signed 32 and signed 64 LEB128 values from a byte
// stream and returns each value or an error code.
// ----------------------------------------------------------------------------
module leb128_integer_decoder (
   input logic      clock,
   input logic      reset,
   leb_req_if.sink  req_chan,
   leb_rsp_if.source rsp_chan
);
   import leb_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   result_type out_ff;
   result_type skid_ff;
   logic       accept;
   logic       out_take;
   logic       new_res;

   leb_step u_step (
      .state      (state_ff),
      .kind       (req_chan.kind),
      .data_byte  (req_chan.data_byte),
      .buffer_end (req_chan.buffer_end),
      .state_next (state_in),
      .result     (step_res)
   );

   assign req_chan.ready      = !skid_ff.valid;
   assign accept              = req_chan.valid && req_chan.ready;
   assign out_take            = out_ff.valid && rsp_chan.ready;
   assign new_res             = accept && step_res.valid;
   assign rsp_chan.valid      = out_ff.valid;
   assign rsp_chan.value      = out_ff.value;
   assign rsp_chan.error_code = out_ff.error_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (skid_ff.valid) begin
            if (out_take) begin
               out_ff        <= skid_ff;
               skid_ff.valid <= 1'b0;
            end
         end else if (new_res) begin
            if (!out_ff.valid || out_take) begin
               out_ff <= step_res;
            end else begin
               skid_ff <= step_res;
            end
         end else if (out_take) begin
            out_ff.valid <= 1'b0;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_ff.valid |-> out_ff.valid)
      else $error("skid entry held without an output entry");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.pos <= LAST_POS_64)
      else $error("byte position beyond the longest encoding");

   a_kind_latched: assert property (@(posedge clock) disable iff (reset)
      (state_ff.pos != 4'd0) |-> (state_ff.kind != KIND_RSV))
      else $error("reserved kind latched for a value in progress");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (new_res && out_ff.valid && !rsp_chan.ready) |=> skid_ff.valid)
      else $error("result lost while output stalled");

endmodule

@@ src/leb_step.sv @@
// ----------------------------------------------------------------------------
// LEB128 byte step
// Folds one byte into the decode state and forms the result it causes.
// ----------------------------------------------------------------------------
module leb_step (
   input  leb_pkg::state_type  state,
   input  logic [1:0]          kind,
   input  logic [7:0]          data_byte,
   input  logic                buffer_end,
   output leb_pkg::state_type  state_next,
   output leb_pkg::result_type result
);
   import leb_pkg::*;

   logic [1:0]  eff_kind;
   logic [3:0]  last_pos;
   logic [3:0]  pos_c;
   logic [5:0]  shamt;
   logic [6:0]  filled;
   logic [63:0] base;
   logic [63:0] acc_new;
   logic [63:0] ext_val;
   logic [63:0] fin_val;
   logic        is_signed;
   logic        is_last;
   logic        range_bad;
   logic [6:0]  pos7;

   always_comb begin
      if (state.pos == 4'd0) begin
         eff_kind = (kind == KIND_RSV) ? KIND_S64 : kind;
         base     = 64'd0;
      end else begin
         eff_kind = state.kind;
         base     = state.acc;
      end
      last_pos  = (eff_kind == KIND_S64) ? LAST_POS_64 : LAST_POS_32;
      pos_c     = (state.pos > last_pos) ? last_pos : state.pos;
      is_signed = (eff_kind != KIND_U32);
      is_last   = (pos_c == last_pos);
      pos7      = {pos_c, 3'b000} - {3'b000, pos_c};
      shamt     = pos7[5:0];
      filled    = pos7 + 7'd7;
      acc_new   = base | ({57'd0, data_byte[6:0]} << shamt);

      ext_val = acc_new;
      if (is_signed && data_byte[6] && (pos_c <= 4'd8)) begin
         ext_val = acc_new | ({64{1'b1}} << filled);
      end
      case (eff_kind)
         KIND_U32: fin_val = {32'd0, ext_val[31:0]};
         KIND_S32: fin_val = {{32{ext_val[31]}}, ext_val[31:0]};
         default:  fin_val = ext_val;
      endcase

      case (eff_kind)
         KIND_U32: range_bad = (data_byte[6:4] != 3'b000);
         KIND_S32: range_bad = (data_byte[7:4] != (data_byte[3] ? 4'h7 : 4'h0));
         default:  range_bad = (data_byte[7:1] != (data_byte[0] ? 7'h3f : 7'h00));
      endcase

      result.valid      = 1'b1;
      result.value      = -64'sd1;
      result.error_code = ERR_OK;
      state_next.acc    = 64'd0;
      state_next.pos    = 4'd0;
      state_next.kind   = eff_kind;

      if (buffer_end) begin
         result.error_code = ERR_LEN_OUT_OF_BOUND;
         state_next.kind   = state.kind;
      end else if (is_last && data_byte[7]) begin
         result.error_code = ERR_REP_TOO_LONG;
      end else if (is_last && range_bad) begin
         result.error_code = ERR_TOO_LARGE;
      end else if (!data_byte[7]) begin
         result.value = fin_val;
      end else begin
         result.valid   = 1'b0;
         state_next.acc = acc_new;
         state_next.pos = pos_c + 4'd1;
      end
   end

endmodule
